/* rtl/core/sorted_key_list_macros.svh */
// Assertion macros shared by the sorted key list RTL.
`ifndef SORTED_KEY_LIST_MACROS_SVH
`define SORTED_KEY_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SKL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_list: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SKL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_list: next-cycle check failed");

`endif

/* rtl/core/skl_pkg.sv */
// Package with the constants, codes and types of the sorted key list.
`timescale 1ns / 1ps
package skl_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FOUND     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic capture;
    logic do_insert;
    logic do_remove;
  } cell_ctl_t;

endpackage

/* rtl/core/skl_in_if.sv */
// Request channel: operation code and key with a valid/ready handshake.
`timescale 1ns / 1ps
interface skl_in_if import skl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

/* rtl/core/skl_out_if.sv */
// Result channel: status and entry count with a valid/ready handshake.
`timescale 1ns / 1ps
interface skl_out_if import skl_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink (input valid, input status, input entry_count, output ready);
endinterface

/* rtl/core/skl_cell.sv */
// One cell of the sorted row: holds a key, compares it and shifts with its neighbours.
`timescale 1ns / 1ps
module skl_cell import skl_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic                    occupied,
  input  logic signed [KEY_W-1:0] cmp_key,
  input  logic signed [KEY_W-1:0] probe,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic                    left_lt,
  input  logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0] key_o,
  output logic                    lt_o,
  output logic                    first_eq_o
);

  logic signed [KEY_W-1:0] key_r;
  logic                    lt_r;
  logic                    eq_r;
  logic                    at_pos;

  // The held keys below the probe form a prefix, so the first cell that is
  // not below it is the one whose left neighbour still is.
  assign at_pos     = !lt_r && left_lt;
  assign first_eq_o = at_pos && eq_r;
  assign lt_o       = lt_r;
  assign key_o      = key_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lt_r <= occupied && (key_r < cmp_key);
      eq_r <= occupied && (key_r == cmp_key);
    end
    if (ctl.do_insert && !lt_r) begin
      key_r <= at_pos ? probe : left_key;
    end else if (ctl.do_remove && !lt_r) begin
      key_r <= right_key;
    end
  end

endmodule

/* rtl/core/skl_chain.sv */
// Row of CAPACITY cells, linked to their neighbours, with the hit reduction.
`timescale 1ns / 1ps
module skl_chain import skl_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic signed [KEY_W-1:0] cmp_key,
  input  logic signed [KEY_W-1:0] probe,
  output logic [CAPACITY-1:0]     hit_vec,
  output logic                    hit
);

  logic signed [KEY_W-1:0] keys [CAPACITY];
  logic [CAPACITY-1:0]     lts;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    occ;
    logic signed [KEY_W-1:0] lkey;
    logic signed [KEY_W-1:0] rkey;
    logic                    llt;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign lkey = probe;
      assign llt  = 1'b1;
    end else begin : g_inner_l
      assign lkey = keys[i-1];
      assign llt  = lts[i-1];
    end

    // The last cell has nothing to its right; what it keeps lies above the count.
    if (i == CAPACITY - 1) begin : g_last
      assign rkey = keys[i];
    end else begin : g_inner_r
      assign rkey = keys[i+1];
    end

    skl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ),
      .cmp_key    (cmp_key),
      .probe      (probe),
      .left_key   (lkey),
      .left_lt    (llt),
      .right_key  (rkey),
      .key_o      (keys[i]),
      .lt_o       (lts[i]),
      .first_eq_o (hit_vec[i])
    );
  end

  assign hit = |hit_vec;

endmodule

/* rtl/core/sorted_key_list.sv */
// Sorted key list: a sequencer driving a row of compare-and-shift cells.
//
// Requests arrive on in_ch (op and signed key) and results leave on out_ch
// (status and entry count), both with valid/ready; a transfer happens on a
// rising edge where both are high. Up to CAPACITY keys are held in ascending
// order; an insert goes in front of any equal keys, a remove drops one match.
//
// Each request is a compare then a shift: in the transfer cycle every cell
// compares its key with the request key in parallel and registers the
// outcome; in the next cycle the row shifts right (insert) or left (remove)
// by one place and the result is written to the output register. No new
// request is taken during that update, so a request is accepted only once
// the one before it has finished its compare then shift sequence.
//
// Synchronous active-low reset empties the list and clears the output valid. The
// stored keys are not cleared; cells at or above the count are never used.
// While the receiver stalls, the result holds in the output register and no
// further request is taken until that result has been transferred.
`timescale 1ns / 1ps
`include "sorted_key_list_macros.svh"
module sorted_key_list import skl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  skl_in_if.sink   in_ch,
  skl_out_if.source out_ch
);

  state_t                  state_r, state_nxt;
  logic [OP_W-1:0]         op_r;
  logic signed [KEY_W-1:0] probe_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 status_r, status_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  cell_ctl_t               ctl;
  logic [CAPACITY-1:0]     hit_vec;
  logic                    hit;
  logic                    full;
  logic                    in_fire;

  assign full         = (count_r == CNT_W'(CAPACITY));
  assign in_ch.ready  = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = out_count_r;

  skl_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .count   (count_r),
    .cmp_key (in_ch.key),
    .probe   (probe_r),
    .hit_vec (hit_vec),
    .hit     (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_ch.op;
      probe_r <= in_ch.key;
    end
    status_r    <= status_nxt;
    out_count_r <= out_count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    out_count_nxt = out_count_r;
    ctl           = '0;
    ctl.capture   = in_fire;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (op_r)
          OP_INSERT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.do_insert = 1'b1;
              count_nxt     = count_r + 1'b1;
              status_nxt    = ST_INSERTED;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              ctl.do_remove = 1'b1;
              count_nxt     = count_r - 1'b1;
              status_nxt    = ST_REMOVED;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          default: begin
            // The spare operation code behaves as a search.
            status_nxt = hit ? ST_FOUND : ST_NOT_FOUND;
          end
        endcase
        out_count_nxt = count_nxt;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `SKL_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SKL_ASSERT_NXT(a_fire_to_update, clk, rst_n, in_fire, state_r == S_UPDATE && !in_ch.ready)
  `SKL_ASSERT_IMP(a_single_match, clk, rst_n, state_r == S_UPDATE, $onehot0(hit_vec))
  `SKL_ASSERT_NXT(a_full_refused, clk, rst_n, state_r == S_UPDATE && op_r == OP_INSERT && full, $stable(count_r) && status_r == ST_FULL)
  `SKL_ASSERT_NXT(a_result_after_update, clk, rst_n, state_r == S_UPDATE, out_valid_r && out_count_r == count_r)

endmodule
